// ===== rtl/core/waypoint_tracking_controller_top_assert.svh =====
// ----------------------------------------------------------------------------
// Waypoint tracking controller assertion macros
// Shared property forms for the controller's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_TRACKING_CONTROLLER_TOP_ASSERT_SVH
`define WAYPOINT_TRACKING_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define WTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtc check failed");

// next-cycle implication
`define WTC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtc check failed");

`endif

// ===== rtl/core/wtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Waypoint tracking controller package
// Fixed-point constants, CORDIC angle table and shared types.
// ----------------------------------------------------------------------------
package wtc_pkg;

    // CORDIC datapath widths
    localparam int CW = 36;
    localparam int ZW = 24;

    localparam int HALF_PI_Q20  = 1647099;
    localparam int PI_Q12       = 12868;
    localparam int TWO_PI_Q12   = 25736;
    localparam int INV_GAIN_Q30 = 652032874;
    localparam int ONE_Q28      = 268435456;

    // configuration register indexes
    localparam logic [2:0] REG_FWD_GAIN    = 3'd0;
    localparam logic [2:0] REG_TURN_P_GAIN = 3'd1;
    localparam logic [2:0] REG_TURN_D_GAIN = 3'd2;
    localparam logic [2:0] REG_SPEED_CAP   = 3'd3;
    localparam logic [2:0] REG_REACH_SQ    = 3'd4;
    localparam logic [2:0] REG_WP_COUNT    = 3'd5;

    typedef struct packed {
        logic                 start;
        logic                 rot;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_rsp_t;

    // atan(2^-i) in Q.20 radians
    function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:  r = 24'sd823550;
            5'd1:  r = 24'sd486170;
            5'd2:  r = 24'sd256879;
            5'd3:  r = 24'sd130396;
            5'd4:  r = 24'sd65451;
            5'd5:  r = 24'sd32757;
            5'd6:  r = 24'sd16383;
            5'd7:  r = 24'sd8192;
            5'd8:  r = 24'sd4096;
            5'd9:  r = 24'sd2048;
            5'd10: r = 24'sd1024;
            5'd11: r = 24'sd512;
            5'd12: r = 24'sd256;
            5'd13: r = 24'sd128;
            5'd14: r = 24'sd64;
            5'd15: r = 24'sd32;
            5'd16: r = 24'sd16;
            5'd17: r = 24'sd8;
            5'd18: r = 24'sd4;
            5'd19: r = 24'sd2;
            5'd20: r = 24'sd1;
            default: r = 24'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/wtc_intf.sv =====
// ----------------------------------------------------------------------------
// Waypoint tracking controller channels
// Pose/waypoint input, command output and configuration write channels.
// ----------------------------------------------------------------------------
interface wtc_in_if;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [5:0]        slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, mode, slot, pos_x, pos_y, quat_w, quat_x, quat_y,
                    quat_z, input ready);
    modport sink (input valid, mode, slot, pos_x, pos_y, quat_w, quat_x, quat_y,
                  quat_z, output ready);
endinterface

interface wtc_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] fwd_speed;
    logic signed [15:0] turn_rate;
    logic [5:0]        target_index;
    logic              finished;

    modport source (output valid, fwd_speed, turn_rate, target_index, finished,
                    input ready);
    modport sink (input valid, fwd_speed, turn_rate, target_index, finished,
                  output ready);
endinterface

interface wtc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wtc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/wtc_cordic.sv =====
// ----------------------------------------------------------------------------
// Shared CORDIC unit
// Vectoring (atan2) or rotation (cos/sin), one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module wtc_cordic #(
    parameter int STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wtc_pkg::cordic_req_t req,
    output wtc_pkg::cordic_rsp_t rsp
);

    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic                          rot_reg;
    logic                          zero_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic signed [wtc_pkg::CW-1:0] x_reg;
    logic signed [wtc_pkg::CW-1:0] y_reg;
    logic signed [wtc_pkg::ZW-1:0] z_reg;

    logic signed [wtc_pkg::CW-1:0] xs;
    logic signed [wtc_pkg::CW-1:0] ys;
    logic signed [wtc_pkg::ZW-1:0] ang;
    logic                          sub;

    // one micro-rotation
    assign xs  = x_reg >>> cnt_reg;
    assign ys  = y_reg >>> cnt_reg;
    assign ang = wtc_pkg::atan_q20(5'(cnt_reg));
    assign sub = rot_reg ? (z_reg >= 0) : (y_reg < 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rot_reg  <= 1'b0;
            zero_reg <= 1'b0;
            cnt_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                // quadrant pre-rotation
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rot_reg  <= req.rot;
                zero_reg <= !req.rot && (req.x == 0) && (req.y == 0);
                if (req.rot)
                begin
                    if (req.z > wtc_pkg::ZW'(wtc_pkg::HALF_PI_Q20))
                    begin
                        x_reg <= '0;
                        y_reg <= wtc_pkg::CW'(wtc_pkg::INV_GAIN_Q30);
                        z_reg <= req.z - wtc_pkg::ZW'(wtc_pkg::HALF_PI_Q20);
                    end
                    else if (req.z < -wtc_pkg::ZW'(wtc_pkg::HALF_PI_Q20))
                    begin
                        x_reg <= '0;
                        y_reg <= -wtc_pkg::CW'(wtc_pkg::INV_GAIN_Q30);
                        z_reg <= req.z + wtc_pkg::ZW'(wtc_pkg::HALF_PI_Q20);
                    end
                    else
                    begin
                        x_reg <= wtc_pkg::CW'(wtc_pkg::INV_GAIN_Q30);
                        y_reg <= '0;
                        z_reg <= req.z;
                    end
                end
                else if (req.x < 0)
                begin
                    if (req.y >= 0)
                    begin
                        x_reg <= req.y;
                        y_reg <= -req.x;
                        z_reg <= wtc_pkg::ZW'(wtc_pkg::HALF_PI_Q20);
                    end
                    else
                    begin
                        x_reg <= -req.y;
                        y_reg <= req.x;
                        z_reg <= -wtc_pkg::ZW'(wtc_pkg::HALF_PI_Q20);
                    end
                end
                else
                begin
                    x_reg <= req.x;
                    y_reg <= req.y;
                    z_reg <= '0;
                end
            end
            else if (busy_reg)
            begin
                if (sub)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // atan2 of the zero vector reads as angle zero
    assign rsp.done = done_reg;
    assign rsp.x    = x_reg;
    assign rsp.y    = y_reg;
    assign rsp.z    = zero_reg ? '0 : z_reg;

endmodule

// ===== rtl/core/waypoint_tracking_controller_top.sv =====
// Waypoint write: accepted while idle, no result beat; the block stays ready.
// Pose tick: three CORDIC passes plus the sequenced multiplies set the time from
// accept to result beat, with a second table read when the target advances.
// A finished tick skips the CORDIC passes and speed/turn steps, giving zero commands.
// Next item taken in the cycle after the result is loaded, while the result beat still waits.
// Reset clears target, finished flag, prev heading error; config to defaults; table not cleared.
// ----------------------------------------------------------------------------
// Waypoint tracking controller
// Differential-drive waypoint follower: reach check, CORDIC yaw and bearing,
// projected forward speed and PD turn rate on one shared multiplier and CORDIC.
// ----------------------------------------------------------------------------
`include "waypoint_tracking_controller_top_assert.svh"

module waypoint_tracking_controller_top #(
    parameter int MAX_WAYPOINTS = 64,
    parameter int CORDIC_STEPS  = 16
) (
    input logic      clk,
    input logic      rst_n,
    wtc_in_if.sink   item,
    wtc_out_if.source result,
    wtc_cfg_if.sink  cfg
);

    localparam int AW    = $clog2(MAX_WAYPOINTS);
    localparam int LIMIT = (MAX_WAYPOINTS < 64) ? MAX_WAYPOINTS : 64;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD, ST_LD, ST_DX2, ST_DY2, ST_CHK, ST_DEC,
        ST_QA, ST_QB, ST_QC, ST_QD, ST_QE, ST_VT, ST_TH, ST_VBR, ST_BR,
        ST_ERR, ST_RS, ST_ROT, ST_PA, ST_PB, ST_PC, ST_VA, ST_VB,
        ST_WA, ST_WB, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] fwd_gain_reg;
    logic [15:0] p_gain_reg;
    logic [15:0] d_gain_reg;
    logic [14:0] cap_reg;
    logic [31:0] reach_reg;
    logic [6:0]  wp_count_reg;

    // controller state
    logic [5:0]         target_reg;
    logic               done_reg;
    logic               adv_reg;
    logic signed [15:0] prev_reg;

    // working registers
    logic signed [15:0] px_reg, py_reg, qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [31:0] s_reg, c_reg;
    logic signed [wtc_pkg::ZW-1:0] theta_reg, bearing_reg;
    logic signed [32:0] co_reg, si_reg;
    logic signed [17:0] proj_reg;
    logic signed [15:0] e_reg;
    logic signed [15:0] fwd_res_reg, turn_res_reg;
    logic signed [50:0] prod_reg;
    logic signed [51:0] acc_reg;

    // result beat
    logic               out_valid_reg;
    logic signed [15:0] out_fwd_reg, out_turn_reg;
    logic [5:0]         out_target_reg;
    logic               out_fin_reg;

    // shared multiplier operands
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;

    wtc_pkg::cordic_req_t creq;
    wtc_pkg::cordic_rsp_t crsp;

    logic [31:0]        rdata;
    logic               ram_we;
    logic [6:0]         n_eff;
    logic               can_adv;
    logic               out_load;
    logic signed [51:0] sum;
    logic               hit;
    logic signed [16:0] b12, t12, diff;
    logic signed [16:0] e_wrap;
    logic signed [51:0] proj_full;
    logic signed [50:0] v_full;
    logic signed [51:0] w_full;

    wtc_ram #(
        .WIDTH(32),
        .DEPTH(MAX_WAYPOINTS)
    ) u_wp_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(AW'(item.slot)),
        .wdata({item.pos_x, item.pos_y}),
        .raddr(AW'(target_reg)),
        .rdata(rdata)
    );

    wtc_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (creq),
        .rsp  (crsp)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign ram_we     = item.valid && item.ready && !item.mode
                        && (32'(item.slot) < MAX_WAYPOINTS);

    // result register loads once the previous beat is gone
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);

    // effective waypoint count: zero acts as one, capped at table size and at 64
    always_comb
    begin
        if (wp_count_reg == 7'd0)
        begin
            n_eff = 7'd1;
        end
        else if (wp_count_reg > 7'(LIMIT))
        begin
            n_eff = 7'(LIMIT);
        end
        else
        begin
            n_eff = wp_count_reg;
        end
    end
    assign can_adv = ({1'b0, target_reg} + 7'd1) < n_eff;

    // accumulate and arithmetic
    assign sum       = acc_reg + 52'(prod_reg);
    assign hit       = sum <= $signed({20'd0, reach_reg});
    assign b12       = 17'((bearing_reg + 24'sd128) >>> 8);
    assign t12       = 17'((theta_reg + 24'sd128) >>> 8);
    assign diff      = b12 - t12;
    assign proj_full = (sum + 52'sd536870912) >>> 30;
    assign v_full    = (prod_reg + 51'sd128) >>> 8;
    assign w_full    = (sum + 52'sd2048) >>> 12;

    // heading error wrap into [-pi, pi]
    always_comb
    begin
        if (diff > 17'(wtc_pkg::PI_Q12))
        begin
            e_wrap = diff - 17'(wtc_pkg::TWO_PI_Q12);
        end
        else if (diff < -17'(wtc_pkg::PI_Q12))
        begin
            e_wrap = diff + 17'(wtc_pkg::TWO_PI_Q12);
        end
        else
        begin
            e_wrap = diff;
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DX2:
            begin
                mul_a = 33'(dx_reg);
                mul_b = 18'(dx_reg);
            end
            ST_DY2:
            begin
                mul_a = 33'(dy_reg);
                mul_b = 18'(dy_reg);
            end
            ST_QA:
            begin
                mul_a = 33'(qw_reg);
                mul_b = 18'(qz_reg);
            end
            ST_QB:
            begin
                mul_a = 33'(qx_reg);
                mul_b = 18'(qy_reg);
            end
            ST_QC:
            begin
                mul_a = 33'(qy_reg);
                mul_b = 18'(qy_reg);
            end
            ST_QD:
            begin
                mul_a = 33'(qz_reg);
                mul_b = 18'(qz_reg);
            end
            ST_PA:
            begin
                mul_a = co_reg;
                mul_b = 18'(dx_reg);
            end
            ST_PB:
            begin
                mul_a = si_reg;
                mul_b = 18'(dy_reg);
            end
            ST_VA:
            begin
                mul_a = $signed({17'd0, fwd_gain_reg});
                mul_b = proj_reg;
            end
            ST_VB:
            begin
                mul_a = $signed({17'd0, p_gain_reg});
                mul_b = 18'(e_reg);
            end
            ST_WA:
            begin
                mul_a = $signed({17'd0, d_gain_reg});
                mul_b = 18'(e_reg) - 18'(prev_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // CORDIC requests
    always_comb
    begin
        creq.start = (state_reg == ST_VT) || (state_reg == ST_VBR) || (state_reg == ST_RS);
        creq.rot   = (state_reg == ST_RS);
        creq.z     = theta_reg;
        if (state_reg == ST_VBR)
        begin
            creq.x = wtc_pkg::CW'(dx_reg) <<< 14;
            creq.y = wtc_pkg::CW'(dy_reg) <<< 14;
        end
        else
        begin
            creq.x = wtc_pkg::CW'(c_reg);
            creq.y = wtc_pkg::CW'(s_reg);
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fwd_gain_reg   <= 16'd768;
            p_gain_reg     <= 16'd512;
            d_gain_reg     <= 16'd256;
            cap_reg        <= 15'd256;
            reach_reg      <= 32'd2621;
            wp_count_reg   <= 7'd1;
            target_reg     <= '0;
            done_reg       <= 1'b0;
            adv_reg        <= 1'b0;
            prev_reg       <= '0;
            out_valid_reg  <= 1'b0;
            px_reg         <= '0;
            py_reg         <= '0;
            qw_reg         <= '0;
            qx_reg         <= '0;
            qy_reg         <= '0;
            qz_reg         <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            s_reg          <= '0;
            c_reg          <= '0;
            theta_reg      <= '0;
            bearing_reg    <= '0;
            co_reg         <= '0;
            si_reg         <= '0;
            proj_reg       <= '0;
            e_reg          <= '0;
            fwd_res_reg    <= '0;
            turn_res_reg   <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            out_fwd_reg    <= '0;
            out_turn_reg   <= '0;
            out_target_reg <= '0;
            out_fin_reg    <= 1'b0;
        end
        else
        begin
            prod_reg <= 51'(mul_a) * 51'(mul_b);

            // config write
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    wtc_pkg::REG_FWD_GAIN:    fwd_gain_reg <= cfg.data[15:0];
                    wtc_pkg::REG_TURN_P_GAIN: p_gain_reg   <= cfg.data[15:0];
                    wtc_pkg::REG_TURN_D_GAIN: d_gain_reg   <= cfg.data[15:0];
                    wtc_pkg::REG_SPEED_CAP:   cap_reg      <= cfg.data[14:0];
                    wtc_pkg::REG_REACH_SQ:    reach_reg    <= cfg.data;
                    wtc_pkg::REG_WP_COUNT:    wp_count_reg <= cfg.data[6:0];
                    default:                  ;
                endcase
            end

            // result beat loads or leaves
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item.valid && item.mode)
                    begin
                        px_reg    <= item.pos_x;
                        py_reg    <= item.pos_y;
                        qw_reg    <= item.quat_w;
                        qx_reg    <= item.quat_x;
                        qy_reg    <= item.quat_y;
                        qz_reg    <= item.quat_z;
                        adv_reg   <= 1'b0;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_LD;
                end
                ST_LD:
                begin
                    dx_reg    <= 17'($signed(rdata[31:16])) - 17'(px_reg);
                    dy_reg    <= 17'($signed(rdata[15:0])) - 17'(py_reg);
                    state_reg <= adv_reg ? ST_DEC : ST_DX2;
                end
                ST_DX2:
                begin
                    state_reg <= ST_DY2;
                end
                ST_DY2:
                begin
                    acc_reg   <= 52'(prod_reg);
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (hit && can_adv)
                    begin
                        target_reg <= target_reg + 6'd1;
                        adv_reg    <= 1'b1;
                        state_reg  <= ST_RD;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            done_reg <= 1'b1;
                        end
                        state_reg <= ST_DEC;
                    end
                end
                ST_DEC:
                begin
                    if (done_reg)
                    begin
                        fwd_res_reg  <= '0;
                        turn_res_reg <= '0;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_QA;
                    end
                end
                ST_QA:
                begin
                    state_reg <= ST_QB;
                end
                ST_QB:
                begin
                    acc_reg   <= 52'(prod_reg);
                    state_reg <= ST_QC;
                end
                ST_QC:
                begin
                    s_reg     <= 32'(sum <<< 1);
                    state_reg <= ST_QD;
                end
                ST_QD:
                begin
                    acc_reg   <= 52'(prod_reg);
                    state_reg <= ST_QE;
                end
                ST_QE:
                begin
                    c_reg     <= 32'(52'(wtc_pkg::ONE_Q28) - (sum <<< 1));
                    state_reg <= ST_VT;
                end
                ST_VT:
                begin
                    state_reg <= ST_TH;
                end
                ST_TH:
                begin
                    if (crsp.done)
                    begin
                        theta_reg <= crsp.z;
                        state_reg <= ST_VBR;
                    end
                end
                ST_VBR:
                begin
                    state_reg <= ST_BR;
                end
                ST_BR:
                begin
                    if (crsp.done)
                    begin
                        bearing_reg <= crsp.z;
                        state_reg   <= ST_ERR;
                    end
                end
                ST_ERR:
                begin
                    e_reg     <= 16'(e_wrap);
                    state_reg <= ST_RS;
                end
                ST_RS:
                begin
                    state_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    if (crsp.done)
                    begin
                        co_reg    <= 33'(crsp.x);
                        si_reg    <= 33'(crsp.y);
                        state_reg <= ST_PA;
                    end
                end
                ST_PA:
                begin
                    state_reg <= ST_PB;
                end
                ST_PB:
                begin
                    acc_reg   <= 52'(prod_reg);
                    state_reg <= ST_PC;
                end
                ST_PC:
                begin
                    proj_reg  <= 18'(proj_full);
                    state_reg <= ST_VA;
                end
                ST_VA:
                begin
                    state_reg <= ST_VB;
                end
                ST_VB:
                begin
                    // forward speed clamp to +-cap
                    if (v_full > $signed({36'd0, cap_reg}))
                    begin
                        fwd_res_reg <= $signed({1'b0, cap_reg});
                    end
                    else if (v_full < -$signed({36'd0, cap_reg}))
                    begin
                        fwd_res_reg <= -$signed({1'b0, cap_reg});
                    end
                    else
                    begin
                        fwd_res_reg <= 16'(v_full);
                    end
                    state_reg <= ST_WA;
                end
                ST_WA:
                begin
                    acc_reg   <= 52'(prod_reg);
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    // turn rate saturation to 16 bits
                    if (w_full > 52'sd32767)
                    begin
                        turn_res_reg <= 16'sh7FFF;
                    end
                    else if (w_full < -52'sd32768)
                    begin
                        turn_res_reg <= 16'sh8000;
                    end
                    else
                    begin
                        turn_res_reg <= 16'(w_full);
                    end
                    prev_reg  <= e_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        out_fwd_reg    <= fwd_res_reg;
                        out_turn_reg   <= turn_res_reg;
                        out_target_reg <= target_reg;
                        out_fin_reg    <= done_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.fwd_speed    = out_fwd_reg;
    assign result.turn_rate    = out_turn_reg;
    assign result.target_index = out_target_reg;
    assign result.finished     = out_fin_reg;

    // checks
    `WTC_ASSERT_IMP(a_fin_zero, result.valid && result.finished,
                    result.fwd_speed == 16'sd0 && result.turn_rate == 16'sd0)
    `WTC_ASSERT_NXT(a_done_sticky, done_reg, done_reg)
    `WTC_ASSERT_IMP(a_busy_no_take, state_reg != ST_IDLE, !item.ready)

endmodule

// ===== tb/sv/waypoint_tracking_controller_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint tracking controller testbench
// Loads waypoint paths and streams pose samples through the controller under
// several register settings. A bit-exact predictor of the reach logic, the
// CORDIC yaw/bearing and the speed/turn laws checks every command beat.
// The sender runs in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module waypoint_tracking_controller_top_tb;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;
    localparam int   NUM_SLOTS  = 64;
    localparam int   STEPS      = 16;
    localparam int   SETTLE     = 120;

    typedef struct packed {
        logic               mode;
        logic [5:0]         slot;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } pose_beat_t;

    typedef struct packed {
        logic signed [15:0] fwd_speed;
        logic signed [15:0] turn_rate;
        logic [5:0]         target_index;
        logic               finished;
    } cmd_beat_t;

    // ------------------------------------------------------------------------
    // Controller predictor and command scoreboard
    // ------------------------------------------------------------------------
    class tracker_scoreboard;
        logic [31:0] wp_store [NUM_SLOTS];
        bit          written [NUM_SLOTS];
        int          target;
        bit          done;
        longint      prev_err;
        longint      fwd_gain, p_gain, d_gain, cap, radius_sq, wp_count;
        longint      atan_q20 [STEPS];
        cmd_beat_t   cmd_expected [$];
        int          errors, ticks, writes, advances;

        function new();
            atan_q20 = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                         4096, 2048, 1024, 512, 256, 128, 64, 32};
            target = 0; done = 0; prev_err = 0;
            fwd_gain = 768; p_gain = 512; d_gain = 256; cap = 256;
            radius_sq = 2621; wp_count = 1;
            errors = 0; ticks = 0; writes = 0; advances = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                wtc_pkg::REG_FWD_GAIN:    fwd_gain  = val[15:0];
                wtc_pkg::REG_TURN_P_GAIN: p_gain    = val[15:0];
                wtc_pkg::REG_TURN_D_GAIN: d_gain    = val[15:0];
                wtc_pkg::REG_SPEED_CAP:   cap       = val[14:0];
                wtc_pkg::REG_REACH_SQ:    radius_sq = val;
                wtc_pkg::REG_WP_COUNT:    wp_count  = val[6:0];
                default: ;
            endcase
        endfunction

        function int eff_count();
            if (wp_count == 0) return 1;
            if (wp_count > NUM_SLOTS) return NUM_SLOTS;
            return int'(wp_count);
        endfunction

        function longint wp_x(int i);
            return longint'($signed(wp_store[i][31:16]));
        endfunction

        function longint wp_y(int i);
            return longint'($signed(wp_store[i][15:0]));
        endfunction

        function bit reaches(logic signed [15:0] px, logic signed [15:0] py);
            longint dx, dy;
            dx = wp_x(target) - longint'(px);
            dy = wp_y(target) - longint'(py);
            return (dx * dx + dy * dy) <= radius_sq;
        endfunction

        // atan2 in Q.20 by CORDIC vectoring
        function longint vector_angle(longint y, longint x);
            longint z, t, nx;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                if (y >= 0) begin t = x; x = y; y = -t; z = wtc_pkg::HALF_PI_Q20; end
                else begin t = x; x = -y; y = t; z = -wtc_pkg::HALF_PI_Q20; end
            end
            for (int i = 0; i < STEPS; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i); y = y - (x >>> i); z += atan_q20[i];
                end else begin
                    nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q20[i];
                end
                x = nx;
            end
            return z;
        endfunction

        // cos/sin in Q.30 by CORDIC rotation
        function void rotate_unit(longint a, output longint co, output longint si);
            longint x, y, nx;
            x = wtc_pkg::INV_GAIN_Q30; y = 0;
            if (a > wtc_pkg::HALF_PI_Q20) begin
                x = 0; y = wtc_pkg::INV_GAIN_Q30; a -= wtc_pkg::HALF_PI_Q20;
            end else if (a < -wtc_pkg::HALF_PI_Q20) begin
                x = 0; y = -wtc_pkg::INV_GAIN_Q30; a += wtc_pkg::HALF_PI_Q20;
            end
            for (int i = 0; i < STEPS; i++) begin
                if (a >= 0) begin
                    nx = x - (y >>> i); y = y + (x >>> i); a -= atan_q20[i];
                end else begin
                    nx = x + (y >>> i); y = y - (x >>> i); a += atan_q20[i];
                end
                x = nx;
            end
            co = x;
            si = y;
        endfunction

        // accepted input beat: update state, queue the command it causes
        function void apply_item(pose_beat_t it);
            longint px, py, dx, dy, qw, qx, qy, qz, s, c, theta, bearing;
            longint e, co, si, proj, v, w;
            cmd_beat_t cmd;
            if (it.mode == MODE_WRITE) begin
                wp_store[it.slot] = {it.pos_x, it.pos_y};
                written[it.slot] = 1;
                writes++;
                return;
            end
            ticks++;
            px = it.pos_x;
            py = it.pos_y;
            if (reaches(it.pos_x, it.pos_y)) begin
                if (target + 1 < eff_count()) begin
                    target++;
                    advances++;
                end else begin
                    done = 1;
                end
            end
            cmd.target_index = target[5:0];
            cmd.finished = done;
            cmd.fwd_speed = '0;
            cmd.turn_rate = '0;
            if (!done) begin
                qw = it.quat_w; qx = it.quat_x; qy = it.quat_y; qz = it.quat_z;
                s = 2 * (qw * qz + qx * qy);
                c = wtc_pkg::ONE_Q28 - 2 * (qy * qy + qz * qz);
                theta = vector_angle(s, c);
                dx = wp_x(target) - px;
                dy = wp_y(target) - py;
                bearing = vector_angle(dy * 16384, dx * 16384);
                e = ((bearing + 128) >>> 8) - ((theta + 128) >>> 8);
                while (e > wtc_pkg::PI_Q12) e -= wtc_pkg::TWO_PI_Q12;
                while (e < -wtc_pkg::PI_Q12) e += wtc_pkg::TWO_PI_Q12;
                rotate_unit(theta, co, si);
                proj = (co * dx + si * dy + (64'sd1 <<< 29)) >>> 30;
                v = (fwd_gain * proj + 128) >>> 8;
                if (v > cap) v = cap;
                if (v < -cap) v = -cap;
                w = (p_gain * e + d_gain * (e - prev_err) + 2048) >>> 12;
                if (w > 32767) w = 32767;
                if (w < -32768) w = -32768;
                prev_err = e;
                cmd.fwd_speed = v[15:0];
                cmd.turn_rate = w[15:0];
            end
            cmd_expected.push_back(cmd);
        endfunction

        task flag_mismatch(string what, longint got, longint want);
            errors++;
            $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        endtask

        task check_command(cmd_beat_t got);
            cmd_beat_t want;
            if (cmd_expected.size() == 0) begin
                errors++;
                $display("[%0t] command beat with nothing expected", $time);
                return;
            end
            want = cmd_expected.pop_front();
            if (got.fwd_speed !== want.fwd_speed)
                flag_mismatch("fwd_speed", got.fwd_speed, want.fwd_speed);
            if (got.turn_rate !== want.turn_rate)
                flag_mismatch("turn_rate", got.turn_rate, want.turn_rate);
            if (got.target_index !== want.target_index)
                flag_mismatch("target_index", got.target_index, want.target_index);
            if (got.finished !== want.finished)
                flag_mismatch("finished", got.finished, want.finished);
        endtask
    endclass

    logic clk;
    logic rst_n;
    wtc_in_if  item_if ();
    wtc_out_if cmd_if ();
    wtc_cfg_if cfg_if ();

    tracker_scoreboard sb;
    int burst_left;
    int stall_cnt;
    int stall_style;

    waypoint_tracking_controller_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if.sink),
        .result (cmd_if.source),
        .cfg    (cfg_if.sink)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver stall pattern: always ready, random, or a fixed duty pattern, style redrawn at random
    always @(negedge clk)
    begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 200 == 0)
            stall_style = $urandom_range(0, 2);
        case (stall_style)
            0:       cmd_if.ready <= 1'b1;
            1:       cmd_if.ready <= ($urandom_range(0, 1) == 1);
            default: cmd_if.ready <= (stall_cnt % 7 < 3);
        endcase
    end

    // command monitor
    always @(posedge clk)
    begin
        if (rst_n && cmd_if.valid && cmd_if.ready)
            sb.check_command('{cmd_if.fwd_speed, cmd_if.turn_rate,
                               cmd_if.target_index, cmd_if.finished});
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("waypoint_tracking_controller_top_tb: FAIL");
        $finish;
    end

    // one input beat; bursts of random length with random gaps between them
    task send_beat(pose_beat_t it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge clk);
                item_if.valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        item_if.valid  <= 1'b1;
        item_if.mode   <= it.mode;
        item_if.slot   <= it.slot;
        item_if.pos_x  <= it.pos_x;
        item_if.pos_y  <= it.pos_y;
        item_if.quat_w <= it.quat_w;
        item_if.quat_x <= it.quat_x;
        item_if.quat_y <= it.quat_y;
        item_if.quat_z <= it.quat_z;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        sb.apply_item(it);
    endtask

    task send_wp(int slot, logic [15:0] wx, logic [15:0] wy);
        pose_beat_t it;
        it = '0;
        it.mode = MODE_WRITE;
        it.slot = slot[5:0];
        it.pos_x = wx;
        it.pos_y = wy;
        it.quat_w = 16'($urandom_range(0, 32768) - 16384);
        it.quat_z = 16'($urandom_range(0, 32768) - 16384);
        send_beat(it);
    endtask

    // pose tick; first loads any waypoint the tick could read, and unless the
    // run may end turns a finishing tick into a waypoint write
    task send_pose(logic [15:0] px, logic [15:0] py, logic [15:0] qw, logic [15:0] qx,
                   logic [15:0] qy, logic [15:0] qz, bit allow_end);
        pose_beat_t it;
        bit hit;
        if (!sb.written[sb.target])
            send_wp(sb.target, 16'($urandom), 16'($urandom));
        hit = sb.reaches(px, py);
        if (hit && sb.target + 1 < sb.eff_count() && !sb.written[sb.target + 1])
            send_wp(sb.target + 1, 16'($urandom), 16'($urandom));
        if (hit && !sb.done && !allow_end && sb.target + 1 >= sb.eff_count()) begin
            send_wp($urandom_range(0, 63), 16'($urandom), 16'($urandom));
            return;
        end
        it = '{MODE_TICK, 6'($urandom), px, py, qw, qx, qy, qz};
        send_beat(it);
    endtask

    function logic [15:0] rand_quat();
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    task idle_input();
        @(negedge clk);
        item_if.valid <= 1'b0;
        burst_left = 0;
    endtask

    // block drained: nothing expected and the write path settled
    task wait_drained();
        while (sb.cmd_expected.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task set_all(logic [31:0] fg, logic [31:0] pg, logic [31:0] dg, logic [31:0] cp,
                 logic [31:0] rs, logic [31:0] cnt);
        write_reg(wtc_pkg::REG_FWD_GAIN, fg);
        write_reg(wtc_pkg::REG_TURN_P_GAIN, pg);
        write_reg(wtc_pkg::REG_TURN_D_GAIN, dg);
        write_reg(wtc_pkg::REG_SPEED_CAP, cp);
        write_reg(wtc_pkg::REG_REACH_SQ, rs);
        write_reg(wtc_pkg::REG_WP_COUNT, cnt);
    endtask

    // random traffic: mostly ticks, some steered onto the current waypoint
    task random_traffic(int n);
        logic [15:0] px, py;
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0) begin
                send_wp($urandom_range(0, 63), 16'($urandom), 16'($urandom));
            end else begin
                px = 16'($urandom);
                py = 16'($urandom);
                if ($urandom_range(0, 19) == 0 && sb.target < 55 && sb.written[sb.target]) begin
                    px = 16'(sb.wp_x(sb.target) + $urandom_range(0, 16) - 8);
                    py = 16'(sb.wp_y(sb.target) + $urandom_range(0, 16) - 8);
                end
                send_pose(px, py, rand_quat(), rand_quat(), rand_quat(), rand_quat(), 1'b0);
            end
        end
    endtask

    initial
    begin
        logic [31:0] rs;
        int n;
        sb = new();
        burst_left = 0;
        stall_cnt = 0;
        stall_style = 0;
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.mode = MODE_WRITE;
        item_if.slot = '0;
        item_if.pos_x = '0;
        item_if.pos_y = '0;
        item_if.quat_w = '0;
        item_if.quat_x = '0;
        item_if.quat_y = '0;
        item_if.quat_z = '0;
        cmd_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, field extremes, special quaternions
        send_wp(0, 16'h1000, 16'h1000);
        send_wp(63, 16'h7fff, 16'h8000);
        send_pose(16'h7fff, 16'h7fff, 16'd16384, 16'd0, 16'd0, 16'd0, 1'b0);
        send_pose(16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_pose(16'h0000, 16'h0000, -16'sd16384, 16'd0, 16'd0, 16'd0, 1'b0);
        send_pose(16'h8000, 16'h7fff, 16'd0, 16'd0, 16'd0, 16'd16384, 1'b0);
        send_pose(16'h7fff, 16'h8000, 16'd0, 16'd0, 16'd0, -16'sd16384, 1'b0);
        send_pose(16'h1000, 16'h8000, 16'd0, 16'd16384, 16'd0, 16'd0, 1'b0);
        send_pose(16'h8000, 16'h1000, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b0);
        send_pose(16'h0ff0, 16'h1010, 16'd11585, 16'd0, 16'd0, -16'sd11585, 1'b0);
        idle_input();
        wait_drained();

        // robot exactly on a waypoint, twice in a row: advance then zero bearing
        set_all(32'd768, 32'd512, 32'd256, 32'd256, 32'd2621, 32'd64);
        send_wp(1, 16'h1000, 16'h1000);
        send_pose(16'h1000, 16'h1000, 16'd16384, 16'd0, 16'd0, 16'd0, 1'b0);
        send_pose(16'h1000, 16'h1000, 16'd0, 16'd0, 16'd0, 16'd16384, 1'b0);
        idle_input();
        wait_drained();

        // random phases under varied settings, extremes first
        for (int ph = 0; ph < 13; ph++)
        begin
            n = 80;
            case (ph)
                0: set_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
                1: set_all(32'hffff, 32'hffff, 32'hffff, 32'h7fff, 32'd4096, 32'h7f);
                2: begin
                    set_all(32'hffff, 32'd0, 32'hffff, 32'h7fff, 32'hffffffff, 32'd64);
                    n = 4;
                end
                default: begin
                    rs = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
                    if (rs > 32'h1000000) n = 4;
                    set_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 32767), rs,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : 64);
                end
            endcase
            random_traffic(n);
            idle_input();
            wait_drained();
        end

        // count lowered below the target, then ticks after finishing
        set_all(32'd768, 32'd512, 32'd256, 32'd256, 32'd2621, 32'd1);
        if (!sb.written[sb.target])
            send_wp(sb.target, 16'h0100, 16'h0200);
        send_pose(16'(sb.wp_x(sb.target)), 16'(sb.wp_y(sb.target)),
                  16'd16384, 16'd0, 16'd0, 16'd0, 1'b1);
        repeat (12)
            send_pose(16'($urandom), 16'($urandom), rand_quat(), rand_quat(), rand_quat(),
                      rand_quat(), 1'b1);
        idle_input();
        wait_drained();

        $display("covered %0d pose ticks and %0d waypoint writes, %0d waypoint advances",
                 sb.ticks, sb.writes, sb.advances);
        $display("finished flag reached: %0d, mismatches: %0d", sb.done, sb.errors);
        if (sb.errors == 0 && sb.cmd_expected.size() == 0)
            $display("waypoint_tracking_controller_top_tb: PASS");
        else
            $display("waypoint_tracking_controller_top_tb: FAIL");
        $finish;
    end

endmodule
